FILE: src/omk_pkg.sv
// ----------------------------------------------------------------------------
// omk_pkg
// Shared types, constants and the sine table generator for the three-wheel
// omni drive kinematics block.
// ----------------------------------------------------------------------------
package omk_pkg;

  // Field widths of the command and the result.
  localparam int CMD_W  = 16;
  localparam int PWM_W  = 11;
  localparam int ARM_W  = 16;

  // Internal datapath widths.
  localparam int TRIG_W = 17;  // signed Q1.15 sine and cosine, +1.0 allowed
  localparam int V0_W   = 20;  // -10 * speed_x
  localparam int V1_W   = 17;  // -speed_y
  localparam int R_W    = 37;  // rotated vector, 19 fraction bits
  localparam int LW_W   = 33;  // arm length times spin rate
  localparam int M_W    = 54;  // rotated y term times cos(30 deg)
  localparam int SUM_W  = 58;  // compare values with FRAC fraction bits
  localparam int FRAC   = 35;

  // Fixed-point constants.
  localparam logic [15:0] COS30_Q16   = 16'd56756;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam int          PWM_MID     = 1000;
  localparam int          PWM_MAX     = 1900;
  localparam int          PWM_MIN     = 100;

  localparam logic signed [SUM_W-1:0] PWM_MID_Q = SUM_W'(PWM_MID) << FRAC;
  localparam logic signed [SUM_W-1:0] PWM_MAX_Q = SUM_W'(PWM_MAX) << FRAC;
  localparam logic signed [SUM_W-1:0] PWM_MIN_Q = SUM_W'(PWM_MIN) << FRAC;

  // One speed command.
  typedef struct packed {
    logic signed [CMD_W-1:0] speed_x;
    logic signed [CMD_W-1:0] speed_y;
    logic signed [CMD_W-1:0] spin_rate;
    logic        [CMD_W-1:0] heading;
    logic                    field_frame;
  } omk_cmd_t;

  // Rotated command and the raw rotation term.
  typedef struct packed {
    logic signed [R_W-1:0]  r0;
    logic signed [R_W-1:0]  r1;
    logic signed [LW_W-1:0] lw;
  } omk_rot_t;

  // Unclamped compare values of the three wheels.
  typedef struct packed {
    logic signed [SUM_W-1:0] pa;
    logic signed [SUM_W-1:0] pb;
    logic signed [SUM_W-1:0] pc;
  } omk_mix_t;

  // One result item.
  typedef struct packed {
    logic [PWM_W-1:0] pwm_wheel_a;
    logic [PWM_W-1:0] pwm_wheel_b;
    logic [PWM_W-1:0] pwm_wheel_c;
    logic [2:0]       clamp_mask;
  } omk_pwm_t;

  // (a * b) >> 60, for building the table at elaboration.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Divides a series term by (2n)(2n+1).
  function automatic logic [63:0] series_div(input logic [63:0] t, input int n);
    logic [63:0] r;
    unique case (n)
      1:       r = t / 64'd6;
      2:       r = t / 64'd20;
      3:       r = t / 64'd42;
      4:       r = t / 64'd72;
      5:       r = t / 64'd110;
      6:       r = t / 64'd156;
      7:       r = t / 64'd210;
      8:       r = t / 64'd272;
      9:       r = t / 64'd342;
      10:      r = t / 64'd420;
      11:      r = t / 64'd506;
      12:      r = t / 64'd600;
      default: r = t;
    endcase
    return r;
  endfunction

  // Sine of a Q60 angle in radians, rounded to Q1.15 and saturated.
  function automatic logic [14:0] sine_from_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = series_div(mul_q60(term, x2), n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + (64'd1 << 44)) >> 45;
    return (v > 64'd32767) ? 15'h7FFF : v[14:0];
  endfunction

endpackage

FILE: src/omk_if.sv
// ----------------------------------------------------------------------------
// omk_if
// Valid/ready channels for speed commands and wheel compare values.
// ----------------------------------------------------------------------------
interface omk_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic signed [15:0] spin_rate;
  logic        [15:0] heading;
  logic               field_frame;

  modport source (
    output valid, speed_x, speed_y, spin_rate, heading, field_frame,
    input  ready
  );
  modport sink (
    input  valid, speed_x, speed_y, spin_rate, heading, field_frame,
    output ready
  );
endinterface

interface omk_pwm_if;
  logic        valid;
  logic        ready;
  logic [10:0] pwm_wheel_a;
  logic [10:0] pwm_wheel_b;
  logic [10:0] pwm_wheel_c;
  logic [2:0]  clamp_mask;

  modport source (
    output valid, pwm_wheel_a, pwm_wheel_b, pwm_wheel_c, clamp_mask,
    input  ready
  );
  modport sink (
    input  valid, pwm_wheel_a, pwm_wheel_b, pwm_wheel_c, clamp_mask,
    output ready
  );
endinterface

FILE: src/omk_rotate.sv
// ----------------------------------------------------------------------------
// omk_rotate
// Three-stage front end: sine table lookup, products, and the rotation of
// the command vector by the heading.
// ----------------------------------------------------------------------------
module omk_rotate import omk_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int ANGLE_BITS       = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ARM_W-1:0] arm_length_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  omk_cmd_t         cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output omk_rot_t         rot_o
);

  localparam int QB     = ANGLE_BITS - 2;
  localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = QB + IDX_W;

  localparam logic [63:0] RomQ = HALF_PI_Q60 / SINE_TABLE_DEPTH;
  localparam logic [63:0] RomR = HALF_PI_Q60 % SINE_TABLE_DEPTH;
  localparam logic [ANGLE_BITS-1:0] QuarterTurn = ANGLE_BITS'(1) << QB;

  // Quarter-wave sine table, built at elaboration.
  logic [14:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] RomX = RomQ * 64'(k) + (RomR * 64'(k)) / SINE_TABLE_DEPTH;
    localparam logic [14:0] RomV = sine_from_x(RomX);
    assign rom[k] = RomV;
  end

  // Table address for an angle; the mirrored quadrants count down.
  function automatic logic [IDX_W-1:0] rom_addr(input logic [ANGLE_BITS-1:0] a);
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx;
    prod = PROD_W'(a[QB-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
    idx  = prod[PROD_W-1:QB];
    return a[QB] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
  endfunction

  // Stage enables: a stage moves when it is empty or its successor moves.
  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;

  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // Sine and cosine of the heading, or the identity in body frame.
  logic [23:0]              head_ext;
  logic [ANGLE_BITS-1:0]    ang_s, ang_c;
  logic [IDX_W-1:0]         addr_s, addr_c;
  logic [14:0]              mag_s, mag_c;
  logic signed [TRIG_W-1:0] trig_s, trig_c;
  logic signed [TRIG_W-1:0] sin_d, cos_d;
  logic signed [V0_W-1:0]   vx_ext, v0_d;
  logic signed [V1_W-1:0]   v1_d;

  always_comb begin
    head_ext = {cmd_i.heading, 8'h00};
    ang_s    = head_ext[23 -: ANGLE_BITS];
    ang_c    = ang_s + QuarterTurn;
    addr_s   = rom_addr(ang_s);
    addr_c   = rom_addr(ang_c);
    mag_s    = (addr_s == IDX_W'(SINE_TABLE_DEPTH)) ? 15'h7FFF : rom[addr_s[ROM_AW-1:0]];
    mag_c    = (addr_c == IDX_W'(SINE_TABLE_DEPTH)) ? 15'h7FFF : rom[addr_c[ROM_AW-1:0]];
    trig_s   = ang_s[QB+1] ? -$signed({2'b00, mag_s}) : $signed({2'b00, mag_s});
    trig_c   = ang_c[QB+1] ? -$signed({2'b00, mag_c}) : $signed({2'b00, mag_c});
    if (cmd_i.field_frame) begin
      sin_d = trig_s;
      cos_d = trig_c;
    end else begin
      sin_d = '0;
      cos_d = TRIG_W'(32768);
    end
    vx_ext = V0_W'(cmd_i.speed_x);
    v0_d   = -((vx_ext <<< 3) + (vx_ext <<< 1));
    v1_d   = -V1_W'(cmd_i.speed_y);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  // Stage A: operands.
  logic signed [V0_W-1:0]   v0_q;
  logic signed [V1_W-1:0]   v1_q;
  logic signed [CMD_W-1:0]  w_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      v0_q  <= v0_d;
      v1_q  <= v1_d;
      w_q   <= cmd_i.spin_rate;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  // Stage B: the four rotation products and the spin term.
  logic signed [R_W-1:0]  cv0_q, sv1_q, sv0_q, cv1_q;
  logic signed [LW_W-1:0] lw_q;

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      cv0_q <= R_W'(cos_q) * R_W'(v0_q);
      sv1_q <= R_W'(sin_q) * R_W'(v1_q);
      sv0_q <= R_W'(sin_q) * R_W'(v0_q);
      cv1_q <= R_W'(cos_q) * R_W'(v1_q);
      lw_q  <= LW_W'($signed({1'b0, arm_length_i})) * LW_W'(w_q);
    end
  end

  // Stage C: rotated vector.
  omk_rot_t rot_q;

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      rot_q.r0 <= cv0_q + sv1_q;
      rot_q.r1 <= cv1_q - sv0_q;
      rot_q.lw <= lw_q;
    end
  end

  assign out_valid_o = vc_q;
  assign rot_o       = rot_q;

endmodule

FILE: src/omk_mix.sv
// ----------------------------------------------------------------------------
// omk_mix
// Three-stage wheel matrix: applies the omni wheel rows and folds in the
// 1000 offset, giving unclamped compare values with 35 fraction bits.
// ----------------------------------------------------------------------------
module omk_mix import omk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  omk_rot_t rot_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output omk_mix_t mix_o
);

  logic vd_q, ve_q, vf_q;
  logic en_d, en_e, en_f;

  assign en_f       = !vf_q || out_ready_i;
  assign en_e       = !ve_q || en_f;
  assign en_d       = !vd_q || en_e;
  assign in_ready_o = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (en_d) begin
        vd_q <= in_valid_i;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
      if (en_f) begin
        vf_q <= ve_q;
      end
    end
  end

  // Stage D: cos(30 deg) product of the rotated y term.
  logic signed [M_W-1:0]  m_q;
  logic signed [R_W-1:0]  r0_q;
  logic signed [LW_W-1:0] lw_q;

  always_ff @(posedge clk_i) begin
    if (en_d && in_valid_i) begin
      m_q  <= M_W'(rot_i.r1) * M_W'($signed({1'b0, COS30_Q16}));
      r0_q <= rot_i.r0;
      lw_q <= rot_i.lw;
    end
  end

  // Stage E: offset minus spin and x terms; the middle wheel is done here.
  logic signed [SUM_W-1:0] spin_e, r0_e;
  logic signed [SUM_W-1:0] u_q, pb_e_q;
  logic signed [M_W-1:0]   m_e_q;

  always_comb begin
    spin_e = SUM_W'(lw_q) <<< 23;
    r0_e   = SUM_W'(r0_q) <<< 15;
  end

  always_ff @(posedge clk_i) begin
    if (en_e && vd_q) begin
      u_q    <= PWM_MID_Q - spin_e - r0_e;
      pb_e_q <= PWM_MID_Q - spin_e + (r0_e <<< 1);
      m_e_q  <= m_q;
    end
  end

  // Stage F: the two outer wheels take the y term with opposite signs.
  omk_mix_t mix_q;

  always_ff @(posedge clk_i) begin
    if (en_f && ve_q) begin
      mix_q.pa <= u_q - SUM_W'(m_e_q);
      mix_q.pb <= pb_e_q;
      mix_q.pc <= u_q + SUM_W'(m_e_q);
    end
  end

  assign out_valid_o = vf_q;
  assign mix_o       = mix_q;

endmodule

FILE: src/omk_pwm.sv
// ----------------------------------------------------------------------------
// omk_pwm
// Output stage: clamps each compare value to 100..1900, truncates it, and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module omk_pwm import omk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  omk_mix_t mix_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output omk_pwm_t pwm_o
);

  // Returns the clamp flag above the truncated compare value.
  function automatic logic [PWM_W:0] pwm_of(input logic signed [SUM_W-1:0] p);
    logic [PWM_W:0] r;
    priority if (p >= PWM_MAX_Q) begin
      r = {p != PWM_MAX_Q, PWM_W'(PWM_MAX)};
    end else if (p <= PWM_MIN_Q) begin
      r = {p != PWM_MIN_Q, PWM_W'(PWM_MIN)};
    end else begin
      r = {1'b0, p[FRAC+PWM_W-1:FRAC]};
    end
    return r;
  endfunction

  logic           vg_q;
  logic           en_g;
  logic [PWM_W:0] wa, wb, wc;
  omk_pwm_t       pwm_d, pwm_q;

  assign en_g       = !vg_q || out_ready_i;
  assign in_ready_o = en_g;

  always_comb begin
    wa                = pwm_of(mix_i.pa);
    wb                = pwm_of(mix_i.pb);
    wc                = pwm_of(mix_i.pc);
    pwm_d.pwm_wheel_a = wa[PWM_W-1:0];
    pwm_d.pwm_wheel_b = wb[PWM_W-1:0];
    pwm_d.pwm_wheel_c = wc[PWM_W-1:0];
    pwm_d.clamp_mask  = {wc[PWM_W], wb[PWM_W], wa[PWM_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en_g) begin
      vg_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_g && in_valid_i) begin
      pwm_q <= pwm_d;
    end
  end

  assign out_valid_o = vg_q;
  assign pwm_o       = pwm_q;

endmodule

FILE: src/omni_wheel_kinematics_pwm.sv
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_pwm
// Three-wheel omni drive inverse kinematics with PWM compare outputs.
// ----------------------------------------------------------------------------
// The block returns the three wheel compare values for each speed command
// that it accepts. It is a seven-stage pipeline (table lookup, rotation
// products, rotation sums, cos(30 deg) product, two stages of wheel sums,
// and the clamping output register), each stage with its own valid bit, so
// throughput is one item per cycle whenever the result side takes items.
// When the result side stalls, the empty stages still fill, and a full
// pipeline holds every item in place. The sine and cosine come from a
// constant quarter-wave table. The arm length register resets to 1.0 and
// must be written only while no item is in flight.
module omni_wheel_kinematics_pwm import omk_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int ANGLE_BITS       = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ARM_W-1:0] cfg_wdata_i,
  omk_cmd_if.sink          cmd_i,
  omk_pwm_if.source        pwm_o
);

  // Arm length register, unsigned Q8.8.
  logic [ARM_W-1:0] arm_length_d, arm_length_q;

  always_comb begin
    arm_length_d = cfg_we_i ? cfg_wdata_i : arm_length_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_length_q <= ARM_W'(256);
    end else begin
      arm_length_q <= arm_length_d;
    end
  end

  // Command payload gathered into one struct.
  omk_cmd_t cmd;

  always_comb begin
    cmd.speed_x     = cmd_i.speed_x;
    cmd.speed_y     = cmd_i.speed_y;
    cmd.spin_rate   = cmd_i.spin_rate;
    cmd.heading     = cmd_i.heading;
    cmd.field_frame = cmd_i.field_frame;
  end

  logic     rot_valid, rot_ready;
  omk_rot_t rot;
  logic     mix_valid, mix_ready;
  omk_mix_t mix;
  omk_pwm_t res;

  omk_rotate #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ANGLE_BITS       (ANGLE_BITS)
  ) u_rotate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .arm_length_i (arm_length_q),
    .in_valid_i   (cmd_i.valid),
    .in_ready_o   (cmd_i.ready),
    .cmd_i        (cmd),
    .out_valid_o  (rot_valid),
    .out_ready_i  (rot_ready),
    .rot_o        (rot)
  );

  omk_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .rot_i       (rot),
    .out_valid_o (mix_valid),
    .out_ready_i (mix_ready),
    .mix_o       (mix)
  );

  omk_pwm u_pwm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (mix_ready),
    .mix_i       (mix),
    .out_valid_o (pwm_o.valid),
    .out_ready_i (pwm_o.ready),
    .pwm_o       (res)
  );

  // Result item onto the output channel.
  assign pwm_o.pwm_wheel_a = res.pwm_wheel_a;
  assign pwm_o.pwm_wheel_b = res.pwm_wheel_b;
  assign pwm_o.pwm_wheel_c = res.pwm_wheel_c;
  assign pwm_o.clamp_mask  = res.clamp_mask;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the omni wheel kinematics block. Speed commands go
// in over the command channel and an in-bench predictor computes the wheel
// compare values and clamp flags of each accepted item that has no directed
// expected result. Every result item is checked against the oldest pending
// prediction. Both channels idle at random and arm length changes per phase.
// ----------------------------------------------------------------------------
module tb;
  import omk_pkg::*;

  localparam int     TBL_DEPTH = 256;
  localparam real    HALF_PI   = 1.5707963267948966;
  localparam longint ONE_Q     = longint'(1) << FRAC;
  localparam longint MID_Q     = longint'(PWM_MID) * ONE_Q;
  localparam longint MAX_Q     = longint'(PWM_MAX) * ONE_Q;
  localparam longint MIN_Q     = longint'(PWM_MIN) * ONE_Q;
  localparam longint COS30     = longint'(COS30_Q16);
  localparam int     PHASES    = 6;
  localparam int     PHASE_LEN = 313;

  // One row of the directed table; want is used only when has_want is set.
  typedef struct packed {
    omk_cmd_t cmd;
    logic     has_want;
    omk_pwm_t want;
  } dir_row_t;

  localparam omk_pwm_t NO_WANT = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ARM_W-1:0] cfg_wdata_i;

  omk_cmd_if cmd_if ();
  omk_pwm_if pwm_if ();

  omni_wheel_kinematics_pwm uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_if),
    .pwm_o       (pwm_if)
  );

  // Bench copy of the arm length register and the quarter-wave sine table.
  logic [15:0] arm_len;
  int          sine_rom [TBL_DEPTH];

  omk_pwm_t pending_pwm [$];
  int       fail_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_left;

  // Directed items: zero command, extremes of each field, truncation,
  // exact and just-outside clamp limits, and each heading quadrant.
  dir_row_t dir_rows [0:24] = '{
    {16'sd0,      16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd1000, 11'd1000, 11'd1000, 3'd0},
    {16'h8000,    16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd100,  11'd1900, 11'd100,  3'd7},
    {16'sd32767,  16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd1900, 11'd100,  11'd1900, 3'd7},
    {16'sd1,      16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd1000, 11'd999,  11'd1000, 3'd0},
    {-16'sd1,     16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd999,  11'd1000, 11'd999,  3'd0},
    {16'sd0,      16'h8000,    16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd100,  11'd1000, 11'd1900, 3'd5},
    {16'sd0,      16'sd32767,  16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd1900, 11'd1000, 11'd100,  3'd5},
    {16'sd0,      16'sd0,      16'sd32767,  16'h0000, 1'b0,
     1'b1, 11'd100,  11'd100,  11'd100,  3'd7},
    {16'sd0,      16'sd0,      16'h8000,    16'h0000, 1'b0,
     1'b1, 11'd1900, 11'd1900, 11'd1900, 3'd7},
    {16'sd0,      16'sd0,      16'sd16,     16'h0000, 1'b0,
     1'b1, 11'd999,  11'd999,  11'd999,  3'd0},
    {16'sd0,      16'sd0,      -16'sd14400, 16'h0000, 1'b0,
     1'b1, 11'd1900, 11'd1900, 11'd1900, 3'd0},
    {16'sd0,      16'sd0,      16'sd14400,  16'h0000, 1'b0,
     1'b1, 11'd100,  11'd100,  11'd100,  3'd0},
    {16'sd0,      16'sd0,      -16'sd14401, 16'h0000, 1'b0,
     1'b1, 11'd1900, 11'd1900, 11'd1900, 3'd7},
    {16'sd0,      16'sd0,      16'sd14401,  16'h0000, 1'b0,
     1'b1, 11'd100,  11'd100,  11'd100,  3'd7},
    {-16'sd16,    16'sd0,      16'sd0,      16'h0000, 1'b0,
     1'b1, 11'd995,  11'd1010, 11'd995,  3'd0},
    {16'sd0,      16'sd0,      16'sd0,      16'h1234, 1'b1,
     1'b1, 11'd1000, 11'd1000, 11'd1000, 3'd0},
    {16'sd100,    -16'sd50,    16'sd30,     16'h0000, 1'b1, 1'b0, NO_WANT},
    {16'sd100,    -16'sd50,    16'sd30,     16'h4000, 1'b1, 1'b0, NO_WANT},
    {16'sd100,    -16'sd50,    16'sd30,     16'h8000, 1'b1, 1'b0, NO_WANT},
    {16'sd100,    -16'sd50,    16'sd30,     16'hC000, 1'b1, 1'b0, NO_WANT},
    {16'sd100,    -16'sd50,    16'sd30,     16'hFFFF, 1'b1, 1'b0, NO_WANT},
    {16'h8000,    16'h8000,    16'h8000,    16'h2000, 1'b1, 1'b0, NO_WANT},
    {16'sd32767,  16'sd32767,  16'sd32767,  16'h7FFF, 1'b1, 1'b0, NO_WANT},
    {16'sd7,      16'sd3,      -16'sd5,     16'h0040, 1'b1, 1'b0, NO_WANT},
    {16'sd7,      16'sd3,      -16'sd5,     16'h3FC0, 1'b1, 1'b0, NO_WANT}
  };

  // Clock and run limit.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("** omni_wheel_kinematics_pwm: FAILED **");
    $finish;
  end

  // Signed Q1.15 sine of a binary angle, read from the quarter-wave table.
  function automatic longint trig_q15(input logic [15:0] ang);
    logic [1:0] quad;
    longint     idx;
    longint     mag;
    quad = ang[15:14];
    idx  = (longint'(ang[13:0]) * TBL_DEPTH) >>> 14;
    if (quad[0]) begin
      idx = TBL_DEPTH - idx;
    end
    mag = (idx >= TBL_DEPTH) ? 64'sd32767 : longint'(sine_rom[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  // Converts a wheel speed with FRAC fraction bits into a compare value.
  function automatic logic [PWM_W-1:0] wheel_compare(input longint speed,
                                                     output logic clipped);
    longint p;
    p       = MID_Q - speed;
    clipped = 1'b0;
    if (p >= MAX_Q) begin
      clipped = (p > MAX_Q);
      return PWM_W'(PWM_MAX);
    end
    if (p <= MIN_Q) begin
      clipped = (p < MIN_Q);
      return PWM_W'(PWM_MIN);
    end
    return PWM_W'(p >>> FRAC);
  endfunction

  // Wheel compare values for one command under the current arm length.
  function automatic omk_pwm_t predict_wheels(input omk_cmd_t c);
    longint      v0, v1, w, s, co, r0, r1, rot, sa, sb, sc;
    logic [15:0] ang_c;
    logic [2:0]  clip;
    omk_pwm_t    res;
    v0 = -10 * longint'(c.speed_x);
    v1 = -longint'(c.speed_y);
    w  = longint'(c.spin_rate);
    if (c.field_frame) begin
      ang_c = c.heading + 16'h4000;
      s     = trig_q15(c.heading);
      co    = trig_q15(ang_c);
      r0    = co * v0 + s * v1;
      r1    = -s * v0 + co * v1;
    end else begin
      r0 = v0 * 32768;
      r1 = v1 * 32768;
    end
    rot = longint'(arm_len) * w * (longint'(1) << 23);
    sa  = r0 * 32768 + r1 * COS30 + rot;
    sb  = -r0 * 65536 + rot;
    sc  = r0 * 32768 - r1 * COS30 + rot;
    res.pwm_wheel_a = wheel_compare(sa, clip[0]);
    res.pwm_wheel_b = wheel_compare(sb, clip[1]);
    res.pwm_wheel_c = wheel_compare(sc, clip[2]);
    res.clamp_mask  = clip;
    return res;
  endfunction

  // Speed field mostly in the unclamped range, sometimes anywhere.
  function automatic logic signed [15:0] rand_speed();
    int sel;
    int mag;
    sel = $urandom_range(9);
    if (sel < 5) begin
      mag = $urandom_range(4000);
      return 16'(mag - 2000);
    end
    if (sel < 8) begin
      mag = $urandom_range(32000);
      return 16'(mag - 16000);
    end
    return 16'($urandom);
  endfunction

  // Offers one item after a random gap and records its expected result.
  task automatic send_cmd(input omk_cmd_t c, input logic has_want,
                          input omk_pwm_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.speed_x     <= c.speed_x;
    cmd_if.speed_y     <= c.speed_y;
    cmd_if.spin_rate   <= c.spin_rate;
    cmd_if.heading     <= c.heading;
    cmd_if.field_frame <= c.field_frame;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_pwm.push_back(has_want ? want : predict_wheels(c));
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_pwm.size() != 0);
  endtask

  // Writes the arm length register; only called with nothing in flight.
  task automatic write_arm(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arm_len = value;
  endtask

  // Checks one result item against the oldest prediction.
  task automatic check_result();
    omk_pwm_t got;
    omk_pwm_t want;
    got.pwm_wheel_a = pwm_if.pwm_wheel_a;
    got.pwm_wheel_b = pwm_if.pwm_wheel_b;
    got.pwm_wheel_c = pwm_if.pwm_wheel_c;
    got.clamp_mask  = pwm_if.clamp_mask;
    if (pending_pwm.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] result item with none pending: a=%0d b=%0d c=%0d mask=%b",
                 $realtime, got.pwm_wheel_a, got.pwm_wheel_b, got.pwm_wheel_c,
                 got.clamp_mask);
      end
    end else begin
      want = pending_pwm.pop_front();
      if (got.pwm_wheel_a !== want.pwm_wheel_a || got.pwm_wheel_b !== want.pwm_wheel_b ||
          got.pwm_wheel_c !== want.pwm_wheel_c || got.clamp_mask !== want.clamp_mask) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] mismatch: exp a=%0d b=%0d c=%0d mask=%b, got a=%0d b=%0d c=%0d mask=%b",
                   $realtime, want.pwm_wheel_a, want.pwm_wheel_b, want.pwm_wheel_c,
                   want.clamp_mask, got.pwm_wheel_a, got.pwm_wheel_b,
                   got.pwm_wheel_c, got.clamp_mask);
        end
      end
    end
  endtask

  // Result side: checks accepted items and stalls at random or for a long hold.
  initial begin
    pwm_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pwm_if.valid && pwm_if.ready) begin
        check_result();
      end
      if (hold_left > 0) begin
        pwm_if.ready <= 1'b0;
        hold_left--;
      end else begin
        pwm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases per arm length.
  initial begin
    real         qr;
    omk_cmd_t    cmd;
    logic [15:0] arm_plan [PHASES];

    for (int k = 0; k < TBL_DEPTH; k++) begin
      qr = 32768.0 * $sin(HALF_PI * k / TBL_DEPTH);
      sine_rom[k] = $rtoi($floor(qr + 0.5));
      if (sine_rom[k] > 32767) begin
        sine_rom[k] = 32767;
      end
    end

    fail_count         = 0;
    hold_left          = 0;
    arm_len            = 16'd256;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.speed_x     = '0;
    cmd_if.speed_y     = '0;
    cmd_if.spin_rate   = '0;
    cmd_if.heading     = '0;
    cmd_if.field_frame = 1'b0;
    send_idle_pct      = 22;
    recv_stall_pct     = 79;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset arm length.
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].has_want, dir_rows[i].want);
    end
    drain_results();

    // Random phases, each under its own arm length and idling pattern.
    arm_plan = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1,
                 16'($urandom_range(1023)), 16'd384};
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = (ph < 2) ? 22 : (ph < 4) ? 79 : 0;
      recv_stall_pct = (ph < 2) ? 79 : (ph < 4) ? 22 : 0;
      write_arm(arm_plan[ph]);
      // Long result-side stall while items keep coming fills the pipeline.
      if (ph == 4) begin
        hold_left = 200;
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        cmd.speed_x     = rand_speed();
        cmd.speed_y     = rand_speed();
        cmd.spin_rate   = rand_speed();
        cmd.heading     = 16'($urandom);
        cmd.field_frame = 1'($urandom_range(1));
        send_cmd(cmd, 1'b0, NO_WANT);
      end
      drain_results();
    end

    // Give any stray result item time to arrive.
    repeat (20) @(posedge clk_i);
    fail_count += pending_pwm.size();
    if (fail_count == 0) begin
      $display("** omni_wheel_kinematics_pwm: PASSED **");
    end else begin
      $display("** omni_wheel_kinematics_pwm: FAILED **");
    end
    $finish;
  end

endmodule

FILE: omni_wheel_kinematics_pwm.f
src/omk_pkg.sv
src/omk_if.sv
src/omk_rotate.sv
src/omk_mix.sv
src/omk_pwm.sv
src/omni_wheel_kinematics_pwm.sv
sim/tb.sv
